// ===== hdl/i2cars_pkg.sv =====
// Shared types and constants of the accelerometer read sequencer.
package i2cars_pkg;

   localparam int BYTE_INDEX_W = 3;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 8;

   // Event kinds carried in the func field.
   localparam logic [1:0] FUNC_START  = 2'd0;
   localparam logic [1:0] FUNC_STATUS = 2'd1;
   localparam logic [1:0] FUNC_ERROR  = 2'd2;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_DEVICE_ADDRESS = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_POWER_REGISTER = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_POWER_VALUE    = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_DATA_REGISTER  = 2'd3;

   localparam logic [6:0] DEVICE_ADDRESS_RESET = 7'h53;
   localparam logic [7:0] POWER_REGISTER_RESET = 8'h2D;
   localparam logic [7:0] POWER_VALUE_RESET    = 8'h08;
   localparam logic [7:0] DATA_REGISTER_RESET  = 8'h32;

   // Sequencer phases.
   localparam int PHASE_W = 4;
   localparam logic [PHASE_W-1:0] PH_IDLE        = 4'd0;
   localparam logic [PHASE_W-1:0] PH_START_SENT  = 4'd1;
   localparam logic [PHASE_W-1:0] PH_ADDR_SENT   = 4'd2;
   localparam logic [PHASE_W-1:0] PH_POWER_WRITE = 4'd3;
   localparam logic [PHASE_W-1:0] PH_INIT_READ   = 4'd4;
   localparam logic [PHASE_W-1:0] PH_READ_SB     = 4'd5;
   localparam logic [PHASE_W-1:0] PH_READ_ADDR   = 4'd6;
   localparam logic [PHASE_W-1:0] PH_READ_BTF    = 4'd7;
   localparam logic [PHASE_W-1:0] PH_REP_SB      = 4'd8;
   localparam logic [PHASE_W-1:0] PH_REP_ADDR    = 4'd9;
   localparam logic [PHASE_W-1:0] PH_RECEIVING   = 4'd10;
   localparam logic [PHASE_W-1:0] PH_COMPLETE    = 4'd11;

   typedef struct packed {
      logic [1:0] func;
      logic       start_sent;
      logic       address_acked;
      logic       transfer_finished;
      logic       receive_ready;
      logic       transmit_empty;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic              send_byte_valid;
      logic [7:0]        send_byte;
      logic              request_start;
      logic              request_stop;
      logic              ack_enable;
      logic              ack_disable;
      logic              clear_address_flag;
      logic              peripheral_reset;
      logic              sample_done;
      logic signed [15:0] x_axis;
      logic signed [15:0] y_axis;
      logic signed [15:0] z_axis;
   } rsp_type;

   typedef struct packed {
      logic [6:0] device_address;
      logic [7:0] power_register;
      logic [7:0] power_value;
      logic [7:0] data_register;
   } cfg_type;

   typedef struct packed {
      logic [PHASE_W-1:0]      phase;
      logic [BYTE_INDEX_W-1:0] byte_index;
   } status_type;

endpackage

// ===== hdl/i2cars_if.sv =====
// Request and response channel interfaces of the read sequencer.
interface i2cars_req_if import i2cars_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface i2cars_rsp_if import i2cars_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== hdl/i2cars_core.sv =====
// Sequencer state, received byte store and per-event command decision.
module i2cars_core import i2cars_pkg::*; #(
   parameter int READ_BYTES = 6
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       fire,
   input  req_type    item,
   input  cfg_type    cfg,
   output rsp_type    result,
   output status_type status
);

   localparam logic [BYTE_INDEX_W-1:0] LAST_IDX = BYTE_INDEX_W'(READ_BYTES - 1);
   localparam logic [BYTE_INDEX_W-1:0] FULL_IDX = BYTE_INDEX_W'(READ_BYTES);

   logic [PHASE_W-1:0]      phase_ff, phase_in;
   logic [BYTE_INDEX_W-1:0] byte_index_ff, byte_index_in, idx_inc;
   logic signed [15:0]      x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic [7:0]              store_ff [READ_BYTES];
   logic [7:0]              fresh [6];
   logic [7:0]              wr_addr;
   logic                    rx_write;
   logic                    finish;

   assign wr_addr = {cfg.device_address, 1'b0};
   assign idx_inc = byte_index_ff + BYTE_INDEX_W'(1);

   always_comb begin
      result        = '0;
      phase_in      = phase_ff;
      byte_index_in = byte_index_ff;
      rx_write      = 1'b0;
      finish        = 1'b0;
      unique case (item.func)
         FUNC_START: begin
            result.request_start = 1'b1;
            phase_in             = PH_START_SENT;
            byte_index_in        = '0;
         end
         FUNC_ERROR: begin
            result.request_stop     = 1'b1;
            result.peripheral_reset = 1'b1;
            phase_in                = PH_IDLE;
            byte_index_in           = '0;
         end
         FUNC_STATUS: begin
            unique case (phase_ff)
               PH_START_SENT: if (item.start_sent) begin
                  result.send_byte_valid = 1'b1;
                  result.send_byte       = wr_addr;
                  phase_in               = PH_ADDR_SENT;
               end
               PH_ADDR_SENT: if (item.address_acked) begin
                  result.clear_address_flag = 1'b1;
                  result.send_byte_valid    = 1'b1;
                  result.send_byte          = cfg.power_register;
                  phase_in                  = PH_POWER_WRITE;
               end
               PH_POWER_WRITE: if (item.transmit_empty) begin
                  result.send_byte_valid = 1'b1;
                  result.send_byte       = cfg.power_value;
                  phase_in               = PH_INIT_READ;
               end
               PH_INIT_READ: if (item.transmit_empty) begin
                  result.request_stop  = 1'b1;
                  result.request_start = 1'b1;
                  phase_in             = PH_READ_SB;
               end
               PH_READ_SB: if (item.start_sent) begin
                  result.send_byte_valid = 1'b1;
                  result.send_byte       = wr_addr;
                  phase_in               = PH_READ_ADDR;
               end
               PH_READ_ADDR: if (item.address_acked) begin
                  result.clear_address_flag = 1'b1;
                  result.send_byte_valid    = 1'b1;
                  result.send_byte          = cfg.data_register;
                  phase_in                  = PH_READ_BTF;
               end
               PH_READ_BTF: if (item.transfer_finished) begin
                  result.request_start = 1'b1;
                  phase_in             = PH_REP_SB;
               end
               PH_REP_SB: if (item.start_sent) begin
                  result.send_byte_valid = 1'b1;
                  result.send_byte       = wr_addr | 8'h01;
                  phase_in               = PH_REP_ADDR;
               end
               PH_REP_ADDR: if (item.address_acked) begin
                  result.ack_enable         = 1'b1;
                  result.clear_address_flag = 1'b1;
                  phase_in                  = PH_RECEIVING;
               end
               PH_RECEIVING: if (item.receive_ready) begin
                  rx_write      = 1'b1;
                  byte_index_in = idx_inc;
                  if (idx_inc == LAST_IDX) begin
                     result.ack_disable  = 1'b1;
                     result.request_stop = 1'b1;
                  end else if (idx_inc >= FULL_IDX) begin
                     result.ack_enable  = 1'b1;
                     result.sample_done = 1'b1;
                     finish             = 1'b1;
                     byte_index_in      = '0;
                     phase_in           = PH_COMPLETE;
                  end
               end
               default: ;
            endcase
         end
         default: ;
      endcase
      result.x_axis = x_in;
      result.y_axis = y_in;
      result.z_axis = z_in;
   end

   // Byte positions beyond the read length contribute zero to their axis.
   for (genvar i = 0; i < 6; i++) begin : g_pos
      if (i < READ_BYTES) begin : g_live
         always_ff @(posedge clock) begin
            if (fire && rx_write && byte_index_ff == BYTE_INDEX_W'(i)) begin
               store_ff[i] <= item.rx_byte;
            end
         end
         assign fresh[i] = (rx_write && byte_index_ff == BYTE_INDEX_W'(i)) ?
                           item.rx_byte : store_ff[i];
      end else begin : g_absent
         assign fresh[i] = 8'd0;
      end
   end

   assign x_in = finish ? {fresh[1], fresh[0]} : x_ff;
   assign y_in = finish ? {fresh[3], fresh[2]} : y_ff;
   assign z_in = finish ? {fresh[5], fresh[4]} : z_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         byte_index_ff <= '0;
         x_ff          <= '0;
         y_ff          <= '0;
         z_ff          <= '0;
      end else if (fire) begin
         phase_ff      <= phase_in;
         byte_index_ff <= byte_index_in;
         x_ff          <= x_in;
         y_ff          <= y_in;
         z_ff          <= z_in;
      end
   end

   assign status.phase      = phase_ff;
   assign status.byte_index = byte_index_ff;

endmodule

// ===== hdl/i2c_accel_read_sequencer.sv =====
// Top level of the I2C accelerometer read sequencer.
// This block drives a power write and a register read of an accelerometer over an I2C
// master, one bus event at a time. Each request is a start command, a bus error or a
// status snapshot of the bus controller; each request yields exactly one response
// holding the bus commands to issue and the three held axis values. A request is
// taken into an input register, decided by one pass of sequencer logic and written
// into the response register once that register is free. A new request can be
// accepted in every cycle while the responses are taken. While a finished response
// waits to be taken, one more request is still accepted into the input register,
// and further requests are held off until the response register drains. The
// configuration registers (device address, power register index and value, data
// register index) may be written only while no request is in flight.
module i2c_accel_read_sequencer import i2cars_pkg::*; #(
   parameter int READ_BYTES = 6
) (
   input  logic                   clock,
   input  logic                   reset,
   i2cars_req_if.sink             req_if,
   i2cars_rsp_if.source           rsp_if,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data
);

   cfg_type    cfg_ff, cfg_in;
   req_type    req_item_ff;
   logic       req_valid_ff, req_valid_in;
   rsp_type    rsp_ff, result;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;
   logic       fire;
   logic       req_take;
   status_type status;

   // Configuration registers are simple write-only flops.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_DEVICE_ADDRESS: cfg_in.device_address = csr_write_data[6:0];
            CSR_POWER_REGISTER: cfg_in.power_register = csr_write_data;
            CSR_POWER_VALUE:    cfg_in.power_value    = csr_write_data;
            CSR_DATA_REGISTER:  cfg_in.data_register  = csr_write_data;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.device_address <= DEVICE_ADDRESS_RESET;
         cfg_ff.power_register <= POWER_REGISTER_RESET;
         cfg_ff.power_value    <= POWER_VALUE_RESET;
         cfg_ff.data_register  <= DATA_REGISTER_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // The response register frees up when it is empty or being drained this cycle;
   // the request in the input register is then decided and moves on.
   assign out_free      = !rsp_valid_ff || rsp_if.ready;
   assign fire          = req_valid_ff && out_free;
   assign req_if.ready  = !req_valid_ff || out_free;
   assign req_take      = req_if.valid && req_if.ready;
   assign req_valid_in  = req_take || (req_valid_ff && !fire);
   assign rsp_valid_in  = fire || (rsp_valid_ff && !rsp_if.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         req_item_ff <= req_if.payload;
      end
      if (fire) begin
         rsp_ff <= result;
      end
   end

   i2cars_core #(
      .READ_BYTES (READ_BYTES)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (req_item_ff),
      .cfg    (cfg_ff),
      .result (result),
      .status (status)
   );

   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.payload = rsp_ff;

   // A finished sample always leaves the sequencer in the complete phase.
   assert property (@(posedge clock) disable iff (reset)
      fire && result.sample_done |=> status.phase == PH_COMPLETE && status.byte_index == '0)
      else $error("sample finished without reaching the complete phase");

   // A bus error returns the sequencer to idle with the byte count cleared.
   assert property (@(posedge clock) disable iff (reset)
      fire && req_item_ff.func == FUNC_ERROR |=>
         status.phase == PH_IDLE && status.byte_index == '0)
      else $error("bus error did not return the sequencer to idle");

   // The byte count never reaches the read length between requests.
   assert property (@(posedge clock) disable iff (reset)
      status.byte_index < BYTE_INDEX_W'(READ_BYTES))
      else $error("byte count beyond the read length");

   // A decided request always lands in the response register.
   assert property (@(posedge clock) disable iff (reset)
      fire |=> rsp_valid_ff)
      else $error("decided request lost before the response register");

endmodule
